// ===== src/fpc_pkg.sv =====
// fixed point calculator: shared types, operation and status codes
// no dependencies
`default_nettype none
package fpc_pkg;
	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_POW = 4'd4;
	localparam logic [3:0] OP_SIN = 4'd5;
	localparam logic [3:0] OP_COS = 4'd6;
	localparam logic [3:0] OP_TAN = 4'd7;
	localparam logic [3:0] OP_COT = 4'd8;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;
	localparam logic [1:0] ST_INV = 2'd3;

	localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] FX_MIN = 32'sh80000000;

	// factorial divisors of the series terms, index = power
	function automatic logic [18:0] fact(input logic [3:0] n);
		logic [18:0] f;
		begin
			unique case (n)
				4'd2: f = 19'd2;
				4'd3: f = 19'd6;
				4'd4: f = 19'd24;
				4'd5: f = 19'd120;
				4'd6: f = 19'd720;
				4'd7: f = 19'd5040;
				4'd8: f = 19'd40320;
				4'd9: f = 19'd362880;
				default: f = 19'd1;
			endcase
			return f;
		end
	endfunction

	typedef struct packed {
		logic start;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mul_req_t;
endpackage
`default_nettype wire

// ===== src/fpc_mul.sv =====
// fixed point calculator: bit serial multiplier, floor shift and saturation
// depends on fpc_pkg
`default_nettype none
module fpc_mul import fpc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mul_req_t req,
	output logic done,
	output logic signed [31:0] prod,
	output logic ovf
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [31:0] mcand_q;
	logic [31:0] mplier_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] addend;
	logic signed [63:0] shifted;

	// two's complement: the top bit weighs negative
	always_comb begin
		addend = mplier_q[0] ? ($signed({{32{mcand_q[31]}}, mcand_q}) <<< cnt_q) : 64'sd0;
		if (cnt_q == 6'd31)
			addend = -addend;
		shifted = acc_q >>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= req.a;
			mplier_q <= req.b;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + addend;
			mplier_q <= {1'b0, mplier_q[31:1]};
		end
	end

	always_comb begin
		ovf = 1'b0;
		prod = shifted[31:0];
		if (shifted > 64'sh7fffffff) begin
			ovf = 1'b1;
			prod = FX_MAX;
		end else if (shifted < -64'sh80000000) begin
			ovf = 1'b1;
			prod = FX_MIN;
		end
	end
endmodule
`default_nettype wire

// ===== src/fpc_div.sv =====
// fixed point calculator: restoring divider, one quotient bit per cycle
// depends on fpc_pkg
`default_nettype none
module fpc_div import fpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [63:0] num,
	input  wire logic [31:0] den,
	input  wire logic neg,
	output logic done,
	output logic signed [63:0] quo
);
	logic busy_q;
	logic [6:0] cnt_q;
	logic neg_q;
	logic [63:0] n_q;
	logic [63:0] q_q;
	logic [32:0] rem_q;
	logic [32:0] trial;
	logic [32:0] d_q;

	assign trial = {rem_q[31:0], n_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[63] ? 64'(-num) : num;
			d_q   <= {1'b0, den};
			neg_q <= neg;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[62:0], 1'b0};
			if (trial >= d_q) begin
				rem_q <= trial - d_q;
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule
`default_nettype wire

// ===== src/fixed_point_calculator_unit.sv =====
// fixed point calculator top level: sequencer, stream ports, result register
// depends on fpc_pkg, fpc_mul, fpc_div
// An item needs no multiplier or divider pass for add and sub, one multiply for
// mul, one division for div, one multiply per step for power (exponent steps,
// clamped to MAX_EXPONENT), and for the trig ops nine multiplies plus eight
// term divides, and one more division for tan and cot. The multiplier and
// divider are bit serial. One item is worked at a time; the result register lets
// the next item in while a result waits.
`default_nettype none
module fixed_point_calculator_unit import fpc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int MAX_EXPONENT = 127
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [79:0] s_tdata, // operand_a, operand_b, exponent
	input  wire logic [3:0] s_tuser,  // req_type
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [39:0] m_tdata       // result, status, zero fill
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_WMUL = 4'd2;
	localparam logic [3:0] S_TDIV = 4'd3;
	localparam logic [3:0] S_WTD  = 4'd4;
	localparam logic [3:0] S_FDIV = 4'd5;
	localparam logic [3:0] S_WFD  = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] op_q;
	logic signed [31:0] a_q, b_q;
	logic [7:0] steps_q;
	logic [3:0] k_q;
	logic signed [31:0] pw_q;
	logic signed [63:0] sn_q, cs_q;
	logic ovf_q, dz_q;
	logic signed [31:0] res_q;
	logic out_valid_q;
	logic signed [31:0] ores_q;
	logic [1:0] ost_q;

	mul_req_t mreq;
	logic mdone, movf;
	logic signed [31:0] mprod;
	logic dstart, ddone, dneg;
	logic signed [63:0] dnum, dquo;
	logic [31:0] dden;
	logic signed [31:0] dsrc, ddiv;
	logic signed [7:0] e_in;
	logic signed [64:0] sum;
	logic signed [32:0] as_sum;
	logic sn_ovf, cs_ovf;
	logic signed [31:0] sn_sat, cs_sat;
	logic signed [31:0] fin_res;
	logic [1:0] fin_st;
	logic fin_go;

	fpc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .prod(mprod), .ovf(movf)
	);
	fpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.neg(dneg), .done(ddone), .quo(dquo)
	);

	assign s_tready = (state_q == S_IDLE);
	assign e_in = s_tdata[71:64];
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || m_tready);

	always_comb begin
		sn_ovf = (sn_q > 64'sh7fffffff) || (sn_q < -64'sh80000000);
		cs_ovf = (cs_q > 64'sh7fffffff) || (cs_q < -64'sh80000000);
		sn_sat = sn_ovf ? (sn_q[63] ? FX_MIN : FX_MAX) : sn_q[31:0];
		cs_sat = cs_ovf ? (cs_q[63] ? FX_MIN : FX_MAX) : cs_q[31:0];
	end

	always_comb begin
		mreq.start = (state_q == S_MUL);
		mreq.a = (op_q == OP_MUL) ? a_q : pw_q;
		mreq.b = (op_q == OP_MUL) ? b_q : a_q;
		dstart = (state_q == S_TDIV) || (state_q == S_FDIV);
		dsrc = '0;
		ddiv = '0;
		if (state_q == S_TDIV) begin
			dnum = 64'(pw_q);
			dden = 32'(fact(k_q));
			dneg = pw_q[31];
		end else begin
			if (op_q == OP_DIV) begin
				dsrc = a_q; ddiv = b_q;
			end else if (op_q == OP_TAN) begin
				dsrc = sn_sat; ddiv = cs_sat;
			end else begin
				dsrc = cs_sat; ddiv = sn_sat;
			end
			dnum = 64'(dsrc) <<< FRAC_BITS;
			dden = ddiv[31] ? 32'(-ddiv) : ddiv;
			dneg = dsrc[31] ^ ddiv[31];
		end
		// odd powers feed the sine sum, even powers the cosine sum
		sum = (k_q[0] ? 65'(sn_q) : 65'(cs_q));
		if (!k_q[1])
			sum = sum + 65'(dquo);
		else
			sum = sum - 65'(dquo);
		as_sum = (op_q == OP_SUB) ? (33'(a_q) - 33'(b_q)) : (33'(a_q) + 33'(b_q));
	end

	always_comb begin
		if (op_q > OP_COT) begin
			fin_res = '0; fin_st = ST_INV;
		end else if (dz_q || (op_q == OP_DIV && b_q == '0)) begin
			fin_res = '0; fin_st = ST_DZ;
		end else if (op_q == OP_SIN) begin
			fin_res = sn_sat; fin_st = (ovf_q | sn_ovf | cs_ovf) ? ST_OVF : ST_OK;
		end else if (op_q == OP_COS) begin
			fin_res = cs_sat; fin_st = (ovf_q | sn_ovf | cs_ovf) ? ST_OVF : ST_OK;
		end else begin
			fin_res = res_q; fin_st = ovf_q ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					unique case (s_tuser)
						OP_ADD, OP_SUB: state_q <= S_DONE;
						OP_MUL: state_q <= S_MUL;
						OP_DIV: state_q <= (s_tdata[63:32] == '0) ? S_DONE : S_FDIV;
						OP_POW: state_q <= (e_in > 8'sd0) ? S_MUL : S_DONE;
						OP_SIN, OP_COS, OP_TAN, OP_COT: state_q <= S_MUL;
						default: state_q <= S_DONE;
					endcase
				end
				S_MUL: state_q <= S_WMUL;
				S_WMUL: if (mdone) begin
					if (op_q == OP_MUL)
						state_q <= S_DONE;
					else if (op_q == OP_POW)
						state_q <= (steps_q == 8'd1) ? S_DONE : S_MUL;
					else if (k_q == 4'd0)
						state_q <= S_MUL;
					else
						state_q <= S_TDIV;
				end
				S_TDIV: state_q <= S_WTD;
				S_WTD: if (ddone) begin
					if (k_q == 4'd9)
						state_q <= ((op_q == OP_TAN) || (op_q == OP_COT)) ? S_FDIV : S_DONE;
					else
						state_q <= S_MUL;
				end
				S_FDIV: begin
					if ((op_q == OP_TAN && cs_sat == '0) || (op_q == OP_COT && sn_sat == '0))
						state_q <= S_DONE;
					else
						state_q <= S_WFD;
				end
				S_WFD: if (ddone) state_q <= S_DONE;
				S_DONE: state_q <= S_FIN;
				S_FIN: if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= s_tuser;
				a_q   <= s_tdata[31:0];
				b_q   <= s_tdata[63:32];
				steps_q <= (e_in > 8'sd0) ?
					((32'(e_in) > MAX_EXPONENT) ? 8'(MAX_EXPONENT) : e_in) : 8'd0;
				k_q   <= 4'd0;
				pw_q  <= 32'sd1 <<< FRAC_BITS;
				sn_q  <= '0;
				cs_q  <= 64'sd1 <<< FRAC_BITS;
				ovf_q <= 1'b0;
				dz_q  <= 1'b0;
				res_q <= 32'sd1 <<< FRAC_BITS;
			end
			S_WMUL: if (mdone) begin
				pw_q  <= mprod;
				ovf_q <= ovf_q | movf;
				steps_q <= steps_q - 8'd1;
				k_q   <= k_q + 4'd1;
				if (op_q == OP_MUL || op_q == OP_POW)
					res_q <= mprod;
				else if (k_q == 4'd0)
					sn_q <= 64'(mprod);
			end
			S_WTD: if (ddone) begin
				if (k_q[0])
					sn_q <= sum[63:0];
				else
					cs_q <= sum[63:0];
			end
			S_FDIV: begin
				if ((op_q == OP_TAN && cs_sat == '0) || (op_q == OP_COT && sn_sat == '0))
					dz_q <= 1'b1;
				ovf_q <= ovf_q | sn_ovf | cs_ovf;
			end
			S_WFD: if (ddone) begin
				if (dquo > 64'sh7fffffff) begin
					res_q <= FX_MAX; ovf_q <= 1'b1;
				end else if (dquo < -64'sh80000000) begin
					res_q <= FX_MIN; ovf_q <= 1'b1;
				end else
					res_q <= dquo[31:0];
			end
			S_DONE: begin
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					if (as_sum[32] != as_sum[31]) begin
						res_q <= as_sum[32] ? FX_MIN : FX_MAX; ovf_q <= 1'b1;
					end else
						res_q <= as_sum[31:0];
				end
			end
			S_FIN: if (fin_go) begin
				ores_q <= fin_res;
				ost_q  <= fin_st;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, ost_q, ores_q};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ost_q == ST_DZ || ost_q == ST_INV) |-> ores_q == '0);
endmodule
`default_nettype wire

// ===== tb/tb_fixed_point_calculator_unit.sv =====
// testbench for fixed_point_calculator_unit: directed and random requests over
// the stream ports, each result checked against a built-in fixed point predictor
// depends on fpc_pkg and the calculator rtl
`default_nettype none
module tb_fixed_point_calculator_unit import fpc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int MAX_EXP = 127;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [79:0] s_tdata;
	logic [3:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [39:0] m_tdata;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0] code;
	} calc_result_t;

	calc_result_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	fixed_point_calculator_unit #(.FRAC_BITS(FRAC), .MAX_EXPONENT(MAX_EXP)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint clamp32(input longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// >>> on longint floors toward minus infinity
	function automatic longint fx_product(input longint a, input longint b, inout bit ovf);
		longint p;
		p = a * b;
		return clamp32(p >>> FRAC, ovf);
	endfunction

	function automatic longint fx_quotient(input longint a, input longint b, inout bit ovf);
		return clamp32((a * (64'sd1 <<< FRAC)) / b, ovf);
	endfunction

	function automatic calc_result_t calc_predict(input logic [3:0] op,
			input logic signed [31:0] opa, input logic signed [31:0] opb,
			input logic signed [7:0] ex);
		longint a, b, e, r, sn, cs;
		longint pw[10];
		bit ovf;
		logic [1:0] st;
		calc_result_t res;
		a = opa;
		b = opb;
		e = ex;
		r = 0;
		ovf = 0;
		st = ST_OK;
		case (op)
			OP_ADD: r = clamp32(a + b, ovf);
			OP_SUB: r = clamp32(a - b, ovf);
			OP_MUL: r = fx_product(a, b, ovf);
			OP_DIV: begin
				if (b == 0) st = ST_DZ;
				else r = fx_quotient(a, b, ovf);
			end
			OP_POW: begin
				if (e > MAX_EXP) e = MAX_EXP;
				r = 64'sd1 <<< FRAC;
				for (longint i = 0; i < e; i++) r = fx_product(r, a, ovf);
			end
			OP_SIN, OP_COS, OP_TAN, OP_COT: begin
				pw[0] = 64'sd1 <<< FRAC;
				for (int k = 1; k < 10; k++) pw[k] = fx_product(pw[k-1], a, ovf);
				sn = clamp32(pw[1] - pw[3] / 6 + pw[5] / 120 - pw[7] / 5040
					+ pw[9] / 362880, ovf);
				cs = clamp32((64'sd1 <<< FRAC) - pw[2] / 2 + pw[4] / 24 - pw[6] / 720
					+ pw[8] / 40320, ovf);
				if (op == OP_SIN) r = sn;
				else if (op == OP_COS) r = cs;
				else if (op == OP_TAN) begin
					if (cs == 0) st = ST_DZ;
					else r = fx_quotient(sn, cs, ovf);
				end else begin
					if (sn == 0) st = ST_DZ;
					else r = fx_quotient(cs, sn, ovf);
				end
			end
			default: st = ST_INV;
		endcase
		if (st != ST_OK) r = 0;
		else if (ovf) st = ST_OVF;
		res.value = r[31:0];
		res.code = st;
		return res;
	endfunction

	task automatic send_request(input logic [3:0] op, input logic signed [31:0] opa,
			input logic signed [31:0] opb, input logic signed [7:0] ex);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {ex, opb, opa};
		expected_results.push_back(calc_predict(op, opa, opb, ex));
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver stall pattern, redrawn every cycle
	always @(posedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		calc_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected transfer: result %h status %0d", m_tdata[31:0],
					m_tdata[33:32]);
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				if (m_tdata[31:0] !== exp_res.value) begin
					$error("result: expected %h actual %h", exp_res.value, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[33:32] !== exp_res.code) begin
					$error("status: expected %0d actual %0d", exp_res.code, m_tdata[33:32]);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		s_tvalid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(131071)) - 65536;
			2: return $signed($urandom_range(8388607)) - 4194304;
			3: return $signed($urandom_range(458752)) - 229376;
			4: return $signed($urandom_range(1023)) - 512;
			default: begin
				case ($urandom_range(3))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'd0;
					default: return 32'h00010000;
				endcase
			end
		endcase
	endfunction

	task automatic test_arith_extremes();
		send_request(OP_ADD, 32'h7fffffff, 32'h00000001, 8'sd0);
		send_request(OP_ADD, 32'h80000000, 32'hffffffff, 8'sd0);
		send_request(OP_SUB, 32'h80000000, 32'h00000001, 8'sd0);
		send_request(OP_SUB, 32'h00030000, 32'hfffe8000, 8'sd0);
		send_request(OP_MUL, 32'h80000000, 32'h80000000, 8'sd0);
		send_request(OP_MUL, 32'hffff0001, 32'h00000003, 8'sd0);
		send_request(OP_DIV, 32'h00050000, 32'h00000000, 8'sd0);
		send_request(OP_DIV, 32'h80000000, 32'hffffffff, 8'sd0);
		send_request(OP_DIV, 32'hfff90000, 32'h00020000, 8'sd0);
	endtask

	task automatic test_power_cases();
		send_request(OP_POW, 32'h00020000, 32'hffffffff, 8'sd0);
		send_request(OP_POW, 32'h00020000, 32'h0, -8'sd128);
		send_request(OP_POW, 32'hffff0000, 32'h0, 8'sd127);
		send_request(OP_POW, 32'h00020000, 32'h0, 8'sd20);
		send_request(OP_POW, 32'hfffe8000, 32'h0, 8'sd5);
	endtask

	task automatic test_series_cases();
		send_request(OP_SIN, 32'h0001921f, 32'h0, 8'sd0);
		send_request(OP_COS, 32'h80000000, 32'h0, 8'sd0);
		send_request(OP_TAN, 32'hffff3700, 32'h0, 8'sd0);
		send_request(OP_COT, 32'h00000000, 32'h0, 8'sd0);
		send_request(OP_SIN, 32'h7fffffff, 32'h0, 8'sd0);
		// near pi/2 the cosine series may hit zero
		send_request(OP_TAN, 32'h0001921f, 32'h0, 8'sd0);
		send_request(OP_COT, 32'h00008000, 32'h0, 8'sd0);
		send_request(4'd9, 32'h0, 32'h0, 8'sd0);
		send_request(4'd15, 32'hffffffff, 32'hffffffff, -8'sd1);
	endtask

	task automatic test_random(input int count);
		logic [3:0] op;
		logic signed [7:0] ex;
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
			ex = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12));
			send_request(op, rand_operand(), rand_operand(), ex);
			if (n == count / 2) begin
				wait_drained();
				repeat (300) @(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_arith_extremes();
		test_power_cases();
		test_series_cases();
		send_idle_pct = 38;
		recv_idle_pct = 63;
		test_random(580);
		send_idle_pct = 63;
		recv_idle_pct = 38;
		test_random(580);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(580);
		wait_drained();
		repeat (300) @(posedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
